### design/can_bit_timing_search_top_defines.svh
// Assertion macros for the CAN bit timing search block.
// Used by the port checker; relies on i_clk and i_rst_n in the including scope.
`ifndef CAN_BIT_TIMING_SEARCH_TOP_DEFINES_SVH
`define CAN_BIT_TIMING_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CBTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CBTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked during reset.
`define CBTS_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/cbts_pkg.sv
// Shared types, widths, codes and the microcode program of the bit timing search.
// No dependencies; the top level, the sequencer and the datapath import it.
package cbts_pkg;

    // Field and datapath widths.
    localparam int CLK_W      = 29;
    localparam int Q_W        = 9;
    localparam int RATE_W     = 24;
    localparam int JW_W       = 8;
    localparam int DIV_W      = Q_W + RATE_W;
    localparam int REM_W      = DIV_W;
    localparam int CNT_W      = $clog2(CLK_W + 1);
    localparam int STEP_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = CLK_W;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QMIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QMAX  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_JW    = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [CLK_W-1:0] RST_CLOCK = 29'd80000000;
    localparam logic [Q_W-1:0]   RST_QMIN  = 9'd8;
    localparam logic [Q_W-1:0]   RST_QMAX  = 9'd25;
    localparam logic [JW_W-1:0]  RST_JW    = 8'd1;

    // Program step addresses.
    localparam logic [STEP_W-1:0] S_IDLE  = 4'd0;
    localparam logic [STEP_W-1:0] S_CHECK = 4'd1;
    localparam logic [STEP_W-1:0] S_MUL   = 4'd2;
    localparam logic [STEP_W-1:0] S_DINIT = 4'd3;
    localparam logic [STEP_W-1:0] S_DSTEP = 4'd4;
    localparam logic [STEP_W-1:0] S_TEST  = 4'd5;
    localparam logic [STEP_W-1:0] S_DEC   = 4'd6;
    localparam logic [STEP_W-1:0] S_SEG1  = 4'd7;
    localparam logic [STEP_W-1:0] S_SEG2  = 4'd8;
    localparam logic [STEP_W-1:0] S_NFND  = 4'd9;
    localparam logic [STEP_W-1:0] S_EMIT  = 4'd10;
    localparam logic [STEP_W-1:0] S_WRAP  = 4'd11;

    // Datapath operations.
    typedef enum logic [3:0] {
        OP_NOP   = 4'd0,
        OP_LOAD  = 4'd1,
        OP_MUL   = 4'd2,
        OP_DINIT = 4'd3,
        OP_DSTEP = 4'd4,
        OP_DEC   = 4'd5,
        OP_SEG1  = 4'd6,
        OP_SEG2  = 4'd7,
        OP_NFND  = 4'd8,
        OP_EMIT  = 4'd9
    } t_op;

    // Jump conditions.
    typedef enum logic [2:0] {
        C_NEVER    = 3'd0,
        C_ALWAYS   = 3'd1,
        C_NO_IN    = 3'd2,
        C_STOP     = 3'd3,
        C_NOT_LAST = 3'd4,
        C_PASS     = 3'd5,
        C_OUT_FULL = 3'd6
    } t_cond;

    // One control word of the program.
    typedef struct packed {
        t_op                op;
        t_cond              cond;
        logic [STEP_W-1:0]  target;
    } t_cw;

    // Status flags fed back from the datapath to the sequencer.
    typedef struct packed {
        logic in_valid;
        logic stop;
        logic not_last;
        logic pass;
        logic out_full;
    } t_stat;

    // Configuration register contents.
    typedef struct packed {
        logic [CLK_W-1:0] clk;
        logic [Q_W-1:0]   qmin;
        logic [Q_W-1:0]   qmax;
        logic [JW_W-1:0]  jw;
    } t_cfg;

    // The microcode program. A taken jump goes to target, otherwise to the next step.
    function automatic t_cw cbts_program(input logic [STEP_W-1:0] addr);
        t_cw w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: S_IDLE};
        unique case (addr)
            S_IDLE:  w = '{op: OP_LOAD,  cond: C_NO_IN,    target: S_IDLE};
            S_CHECK: w = '{op: OP_NOP,   cond: C_STOP,     target: S_NFND};
            S_MUL:   w = '{op: OP_MUL,   cond: C_NEVER,    target: S_IDLE};
            S_DINIT: w = '{op: OP_DINIT, cond: C_NEVER,    target: S_IDLE};
            S_DSTEP: w = '{op: OP_DSTEP, cond: C_NOT_LAST, target: S_DSTEP};
            S_TEST:  w = '{op: OP_NOP,   cond: C_PASS,     target: S_SEG1};
            S_DEC:   w = '{op: OP_DEC,   cond: C_ALWAYS,   target: S_CHECK};
            S_SEG1:  w = '{op: OP_SEG1,  cond: C_NEVER,    target: S_IDLE};
            S_SEG2:  w = '{op: OP_SEG2,  cond: C_ALWAYS,   target: S_EMIT};
            S_NFND:  w = '{op: OP_NFND,  cond: C_NEVER,    target: S_IDLE};
            S_EMIT:  w = '{op: OP_EMIT,  cond: C_OUT_FULL, target: S_EMIT};
            S_WRAP:  w = '{op: OP_NOP,   cond: C_ALWAYS,   target: S_IDLE};
            default: w = '{op: OP_NOP,   cond: C_ALWAYS,   target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

### design/can_bit_timing_search_top.sv
// Each failing quanta count runs the check, multiply, divider set-up, bit-serial divider
// steps, test and decrement; then the not-found step runs when none is found, or the two
// segment steps for the accepted count, before the result is emitted. The default range
// holds 18 counts. One request runs at a time; the divider forms one bit per cycle.
// Reset (synchronous, active low) restores the register defaults, returns the
// sequencer to its idle step and empties the output register.
module can_bit_timing_search_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cbts_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cbts_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [cbts_pkg::RATE_W-1:0]      i_bit_rate,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_found,
    output logic [cbts_pkg::CLK_W-1:0]       o_prescaler,
    output logic [cbts_pkg::Q_W-1:0]         o_phase_seg_one,
    output logic [cbts_pkg::Q_W-1:0]         o_phase_seg_two
);
    import cbts_pkg::*;

    t_cfg  r_cfg;
    t_cw   w_cw;
    t_stat w_stat;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clk  <= RST_CLOCK;
            r_cfg.qmin <= RST_QMIN;
            r_cfg.qmax <= RST_QMAX;
            r_cfg.jw   <= RST_JW;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CLOCK: r_cfg.clk  <= i_cfg_data[CLK_W-1:0];
                CFG_QMIN:  r_cfg.qmin <= i_cfg_data[Q_W-1:0];
                CFG_QMAX:  r_cfg.qmax <= i_cfg_data[Q_W-1:0];
                CFG_JW:    r_cfg.jw   <= i_cfg_data[JW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A new request beat is taken only on the load step of the program.
    assign o_in_ready = (w_cw.op == OP_LOAD);

    cbts_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cw    (w_cw)
    );

    cbts_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cw            (w_cw),
        .i_cfg           (r_cfg),
        .i_in_valid      (i_in_valid),
        .i_bit_rate      (i_bit_rate),
        .i_out_ready     (i_out_ready),
        .o_stat          (w_stat),
        .o_out_valid     (o_out_valid),
        .o_found         (o_found),
        .o_prescaler     (o_prescaler),
        .o_phase_seg_one (o_phase_seg_one),
        .o_phase_seg_two (o_phase_seg_two)
    );

endmodule

### design/cbts_seq.sv
// Microcode sequencer: step counter, program lookup and conditional jumps.
// Depends on cbts_pkg for the program table, control word and status types.
module cbts_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cbts_pkg::t_stat i_stat,
    output cbts_pkg::t_cw   o_cw
);
    import cbts_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_cw               w_cw;
    logic              w_take;

    // Fetch the control word of the current step.
    assign w_cw = cbts_program(r_step);
    assign o_cw = w_cw;

    // Evaluate the jump condition of this step.
    always_comb begin
        unique case (w_cw.cond)
            C_NEVER:    w_take = 1'b0;
            C_ALWAYS:   w_take = 1'b1;
            C_NO_IN:    w_take = ~i_stat.in_valid;
            C_STOP:     w_take = i_stat.stop;
            C_NOT_LAST: w_take = i_stat.not_last;
            C_PASS:     w_take = i_stat.pass;
            C_OUT_FULL: w_take = i_stat.out_full;
            default:    w_take = 1'b0;
        endcase
        n_step = w_take ? w_cw.target : STEP_W'(r_step + 1'b1);
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

### design/cbts_dp.sv
// Datapath of the bit timing search: operands, multiplier, bit-serial divider,
// segment arithmetic and the output register. Depends on cbts_pkg.
module cbts_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cbts_pkg::t_cw                i_cw,
    input  cbts_pkg::t_cfg               i_cfg,
    input  logic                         i_in_valid,
    input  logic [cbts_pkg::RATE_W-1:0]  i_bit_rate,
    input  logic                         i_out_ready,
    output cbts_pkg::t_stat              o_stat,
    output logic                         o_out_valid,
    output logic                         o_found,
    output logic [cbts_pkg::CLK_W-1:0]   o_prescaler,
    output logic [cbts_pkg::Q_W-1:0]     o_phase_seg_one,
    output logic [cbts_pkg::Q_W-1:0]     o_phase_seg_two
);
    import cbts_pkg::*;

    // Working registers.
    logic [RATE_W-1:0] r_rate;
    logic [Q_W-1:0]    r_q;
    logic [DIV_W-1:0]  r_div;
    logic [REM_W-1:0]  r_rem;
    logic [CLK_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_cnt;
    logic [Q_W-1:0]    r_s1;
    logic              r_res_found;
    logic [CLK_W-1:0]  r_res_pre;
    logic [Q_W-1:0]    r_res_s2;

    // Output register.
    logic              r_out_valid;
    logic              r_out_found;
    logic [CLK_W-1:0]  r_out_pre;
    logic [Q_W-1:0]    r_out_s1;
    logic [Q_W-1:0]    r_out_s2;

    logic [Q_W-1:0]    w_qmin;
    logic [REM_W:0]    w_try;
    logic [REM_W:0]    w_div_ext;
    logic [REM_W:0]    w_sub;
    logic              w_ge;
    logic [REM_W+3:0]  w_rem10;
    logic              w_pass;
    logic [Q_W+1:0]    w_q3;
    logic [Q_W-1:0]    w_q34;
    logic [Q_W-1:0]    w_jw_ext;
    logic [Q_W-1:0]    w_s1;
    logic [Q_W:0]      w_sum;
    logic [Q_W-1:0]    w_s2;
    logic              w_out_full;

    // A minimum of zero is treated as one, so a count of zero is never tried.
    assign w_qmin = (i_cfg.qmin == '0) ? Q_W'(1) : i_cfg.qmin;

    // One restoring division step: shift in the next clock bit, subtract if it fits.
    assign w_try     = {r_rem, r_quo[CLK_W-1]};
    assign w_div_ext = {1'b0, r_div};
    assign w_ge      = (w_try >= w_div_ext);
    assign w_sub     = w_try - w_div_ext;

    // Acceptance test: ten times the remainder below the divisor.
    assign w_rem10 = {1'b0, r_rem, 3'b000} + {3'b000, r_rem, 1'b0};
    assign w_pass  = (w_rem10 < {4'b0000, r_div});

    // Segment one is three quarters of the count less the jump width, floored at zero.
    assign w_q3     = {2'b00, r_q} + {1'b0, r_q, 1'b0};
    assign w_q34    = w_q3[Q_W+1:2];
    assign w_jw_ext = {{(Q_W-JW_W){1'b0}}, i_cfg.jw};
    assign w_s1     = (w_q34 > w_jw_ext) ? (w_q34 - w_jw_ext) : '0;

    // Segment two takes what is left of the count, floored at zero.
    assign w_sum = {1'b0, r_s1} + {{(Q_W+1-JW_W){1'b0}}, i_cfg.jw} + (Q_W+1)'(1);
    assign w_s2  = ({1'b0, r_q} > w_sum) ? (r_q - w_sum[Q_W-1:0]) : '0;

    // The output register is full while its beat waits to be taken.
    assign w_out_full = r_out_valid & ~i_out_ready;

    // Status back to the sequencer.
    always_comb begin
        o_stat.in_valid = i_in_valid;
        o_stat.stop     = (r_rate == '0) | (r_q < w_qmin);
        o_stat.not_last = (r_cnt != CNT_W'(1));
        o_stat.pass     = w_pass;
        o_stat.out_full = w_out_full;
    end

    // Operations selected by the control word.
    always_ff @(posedge i_clk) begin
        unique case (i_cw.op)
            OP_LOAD: begin
                if (i_in_valid) begin
                    r_rate <= i_bit_rate;
                    r_q    <= i_cfg.qmax;
                end
            end
            OP_MUL: begin
                r_div <= DIV_W'(r_q) * DIV_W'(r_rate);
            end
            OP_DINIT: begin
                r_rem <= '0;
                r_quo <= i_cfg.clk;
                r_cnt <= CNT_W'(CLK_W);
            end
            OP_DSTEP: begin
                r_rem <= w_ge ? w_sub[REM_W-1:0] : w_try[REM_W-1:0];
                r_quo <= {r_quo[CLK_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
            end
            OP_DEC: begin
                r_q <= r_q - 1'b1;
            end
            OP_SEG1: begin
                r_s1      <= w_s1;
                r_res_pre <= r_quo;
            end
            OP_SEG2: begin
                r_res_s2    <= w_s2;
                r_res_found <= 1'b1;
            end
            OP_NFND: begin
                r_res_found <= 1'b0;
                r_res_pre   <= '0;
                r_s1        <= '0;
                r_res_s2    <= '0;
            end
            OP_EMIT: begin
                if (!w_out_full) begin
                    r_out_found <= r_res_found;
                    r_out_pre   <= r_res_pre;
                    r_out_s1    <= r_s1;
                    r_out_s2    <= r_res_s2;
                end
            end
            default: begin
            end
        endcase
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cw.op == OP_EMIT && !w_out_full) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_out_found;
    assign o_prescaler     = r_out_pre;
    assign o_phase_seg_one = r_out_s1;
    assign o_phase_seg_two = r_out_s2;

endmodule

### design/cbts_checker.sv
// Port-level checker for the bit timing search, bound to the top level.
// Depends on cbts_pkg for widths and on the assertion macro header.
`include "can_bit_timing_search_top_defines.svh"

module cbts_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic                             o_found,
    input logic [cbts_pkg::CLK_W-1:0]       o_prescaler,
    input logic [cbts_pkg::Q_W-1:0]         o_phase_seg_one,
    input logic [cbts_pkg::Q_W-1:0]         o_phase_seg_two
);

    // A stalled result beat keeps its payload.
    `CBTS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_found) && $stable(o_prescaler) &&
        $stable(o_phase_seg_one) && $stable(o_phase_seg_two),
        "result beat changed while stalled")

    // Once a request beat is taken, no second one is taken until the search ends.
    `CBTS_ASSERT_NEXT(a_one_at_a_time, i_in_valid && o_in_ready, !o_in_ready,
        "request taken while a search is running")

    // A not-found result carries zeros in every other field.
    `CBTS_ASSERT_NOW(a_nf_zero, o_out_valid && !o_found,
        o_prescaler == '0 && o_phase_seg_one == '0 && o_phase_seg_two == '0,
        "not-found result has non-zero fields")

    // Reset empties the output register.
    `CBTS_ASSERT_RST(a_rst_empty, !i_rst_n, !o_out_valid, "result valid straight after reset")

endmodule

bind can_bit_timing_search_top cbts_checker u_cbts_checker (.*);
